>>> src/wwr_pkg.sv
`timescale 1ns / 1ps
package wwr_pkg;

   // Longest pattern held, and longest replacement.
   localparam int MaxPattern = 8;
   localparam int MaxReplace = 8;
   // A step can emit a whole held word or replacement plus one more byte.
   localparam int JobBytes = MaxPattern + 1;
   localparam int LenWidth = 4;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 64;

   localparam logic [CsrIndexWidth-1:0] RegPatternBytes     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegPatternLength    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegReplacementBytes = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegReplacementLength = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegDelimiter        = 3'd4;

   typedef struct packed {
      logic [7:0] in_char;
      logic       text_end_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       text_end_out;
   } rsp_type;

   // The bytes one input beat produces, in order, ready for the back end.
   typedef struct packed {
      logic [JobBytes-1:0][7:0] bytes;
      logic [LenWidth-1:0]      count;
      logic                     text_end;
   } job_type;

endpackage

>>> src/wwr_front.sv
`timescale 1ns / 1ps
module wwr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  wwr_pkg::req_type                   req,
   input  logic                               csr_write_enable,
   input  logic [wwr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [wwr_pkg::CsrDataWidth-1:0]   csr_write_data,
   output wwr_pkg::job_type                   job
);
   import wwr_pkg::*;

   logic [63:0]         pattern_ff;
   logic [LenWidth-1:0] pattern_len_ff;
   logic [63:0]         replace_ff;
   logic [LenWidth-1:0] replace_len_ff;
   logic [7:0]          delimiter_ff;

   logic [MaxPattern-1:0][7:0] store_ff;
   logic [LenWidth-1:0]        fill_ff;
   logic [LenWidth-1:0]        fill_in;
   logic                       pass_ff;
   logic                       pass_in;

   logic [MaxPattern-1:0][7:0] view;
   logic [LenWidth-1:0]        plen;
   logic [LenWidth-1:0]        rlen;
   logic [LenWidth-1:0]        word_len;
   logic [LenWidth-1:0]        base;
   logic [MaxPattern-1:0]      byte_ok;
   logic                       is_delim;
   logic                       room;
   logic                       match;
   logic                       use_repl;
   logic                       append;
   logic                       store_write;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      begin
         upcase = (c >= 8'h61 && c <= 8'h7a) ? (c - 8'd32) : c;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         pattern_len_ff <= LenWidth'(1);
         replace_ff     <= '0;
         replace_len_ff <= '0;
         delimiter_ff   <= 8'd32;
      end else if (csr_write_enable) begin
         case (csr_index)
            RegPatternBytes:      pattern_ff     <= csr_write_data[63:0];
            RegPatternLength:     pattern_len_ff <= csr_write_data[LenWidth-1:0];
            RegReplacementBytes:  replace_ff     <= csr_write_data[63:0];
            RegReplacementLength: replace_len_ff <= csr_write_data[LenWidth-1:0];
            RegDelimiter:         delimiter_ff   <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      plen = pattern_len_ff;
      if (plen == '0) plen = LenWidth'(1);
      if (plen > LenWidth'(MaxPattern)) plen = LenWidth'(MaxPattern);
      rlen = (replace_len_ff > LenWidth'(MaxReplace)) ? LenWidth'(MaxReplace)
                                                        : replace_len_ff;
   end

   // The held word with the incoming byte placed after it; a delimiter never
   // reaches that position in the comparison, so one view serves both cases.
   always_comb begin
      for (int i = 0; i < MaxPattern; i++) begin
         view[i] = (fill_ff == LenWidth'(i)) ? req.in_char : store_ff[i];
      end
   end

   assign is_delim = (req.in_char == delimiter_ff);
   assign room     = (fill_ff < plen);
   assign word_len = is_delim ? fill_ff : (fill_ff + LenWidth'(1));

   always_comb begin
      for (int i = 0; i < MaxPattern; i++) begin
         byte_ok[i] = (LenWidth'(i) >= plen) ||
                      (upcase(view[i]) == upcase(pattern_ff[8*i +: 8]));
      end
      match = (word_len == plen) && (&byte_ok);
   end

   always_comb begin
      base     = '0;
      use_repl = 1'b0;
      append   = 1'b1;
      if (is_delim) begin
         if (!pass_ff) begin
            if (match) begin
               use_repl = 1'b1;
               base     = rlen;
            end else begin
               base = fill_ff;
            end
         end
      end else if (pass_ff) begin
         base = '0;
      end else if (room) begin
         append = 1'b0;
         if (req.text_end_in) begin
            if (match) begin
               use_repl = 1'b1;
               base     = rlen;
            end else begin
               base = word_len;
            end
         end
      end else begin
         base = fill_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < JobBytes; i++) begin
         job.bytes[i] = req.in_char;
         if (i < MaxPattern && LenWidth'(i) < base) begin
            job.bytes[i] = use_repl ? replace_ff[8*(i % MaxPattern) +: 8]
                                    : view[i % MaxPattern];
         end
      end
      job.count    = base + LenWidth'(append);
      job.text_end = req.text_end_in;
   end

   assign store_write = !is_delim && !pass_ff && room;

   always_comb begin
      fill_in = fill_ff;
      pass_in = pass_ff;
      if (is_delim || req.text_end_in) begin
         fill_in = '0;
         pass_in = 1'b0;
      end else if (!pass_ff) begin
         if (room) begin
            fill_in = fill_ff + LenWidth'(1);
         end else begin
            fill_in = '0;
            pass_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pass_ff <= 1'b0;
      end else if (accept) begin
         fill_ff <= fill_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_write) begin
         store_ff[fill_ff[$clog2(MaxPattern)-1:0]] <= req.in_char;
      end
   end

endmodule

>>> src/wwr_queue.sv
`timescale 1ns / 1ps
module wwr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wwr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output wwr_pkg::job_type pop_job
);
   import wwr_pkg::*;

   job_type     mem_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> src/wwr_back.sv
`timescale 1ns / 1ps
module wwr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_ready,
   input  wwr_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wwr_pkg::rsp_type rsp_payload
);
   import wwr_pkg::*;

   job_type             cur_ff;
   logic                cur_valid_ff;
   logic [LenWidth-1:0] pos_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic out_free;
   logic emit;
   logic last;
   logic cur_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;
   assign last     = (pos_ff == cur_ff.count - LenWidth'(1));
   assign cur_done = !cur_valid_ff || (emit && last);
   assign job_pop  = cur_done && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A job that produces no bytes is dropped as it is loaded.
         if (job_pop) begin
            cur_valid_ff <= (job.count != '0);
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
         pos_ff <= '0;
      end else if (emit && !last) begin
         pos_ff <= pos_ff + LenWidth'(1);
      end
      if (emit) begin
         rsp_ff.out_char     <= cur_ff.bytes[pos_ff];
         rsp_ff.run_last     <= last;
         rsp_ff.text_end_out <= last && cur_ff.text_end;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> src/whole_word_replace_stream.sv
`timescale 1ns / 1ps
// Path: job queue, then current-job register, then registered output beat.
// Throughput: one input beat per cycle while the output is not stalled and each
// beat causes at most one result; a beat causing n results holds the output for
// all of them in turn, and the two-entry job queue between classifier and
// serialiser absorbs short bursts. Reset (synchronous, active high) clears the
// word state, the queue and the output, and loads the register defaults.
module whole_word_replace_stream (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wwr_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wwr_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [wwr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [wwr_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import wwr_pkg::*;

   job_type front_job;
   job_type queue_job;
   logic    queue_full;
   logic    queue_ready;
   logic    queue_pop;
   logic    accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   wwr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req              (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .job              (front_job)
   );

   wwr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_ready),
      .pop_job   (queue_job)
   );

   wwr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_ready   (queue_ready),
      .job         (queue_job),
      .job_pop     (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
   import wwr_pkg::*;

   localparam int StallLimit = 3000;
   localparam logic [CsrIndexWidth-1:0] RegUnused = 3'd7;

   typedef struct packed {
      req_type stim;
      logic    typed;
      rsp_type want;
   } script_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_payload;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_write_data = '0;

   // Predictor copy of the registers, at their reset values.
   logic [63:0] cfg_pattern = '0;
   logic [3:0]  cfg_pattern_len = 4'd1;
   logic [63:0] cfg_repl = '0;
   logic [3:0]  cfg_repl_len = 4'd0;
   logic [7:0]  cfg_delim = 8'h20;

   // Predictor copy of the word state.
   logic [7:0]  held_word [MaxPattern];
   int unsigned held_count = 0;
   logic        overflowing = 1'b0;

   logic [7:0]     beat_bytes [$];
   rsp_type        expected_text [$];
   req_type        text_beats [$];
   script_row_type text_script [22];

   int          errors = 0;
   int          idle_pct = 15;
   int          stall_pct = 15;
   int          stall_left = 0;
   int          idle_cycles = 0;
   rsp_type     seen_want;

   whole_word_replace_stream dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   function automatic int unsigned pattern_span();
      if (cfg_pattern_len < 1) return 1;
      if (cfg_pattern_len > MaxPattern) return MaxPattern;
      return cfg_pattern_len;
   endfunction

   function automatic script_row_type row(input logic [7:0] ch, input logic fin,
                                          input logic typed, input logic [7:0] want_ch,
                                          input logic want_end);
      script_row_type r;
      r.stim.in_char = ch;
      r.stim.text_end_in = fin;
      r.typed = typed;
      r.want.out_char = want_ch;
      r.want.run_last = 1'b1;
      r.want.text_end_out = want_end;
      return r;
   endfunction

   function automatic req_type plain_byte(input logic [7:0] b);
      req_type t;
      t.in_char = b;
      t.text_end_in = 1'b0;
      return t;
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] b);
      if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(1) == 1)
         return b ^ 8'h20;
      return b;
   endfunction

   task automatic close_word();
      logic        hit;
      int unsigned span;
      int unsigned rspan;
      span = pattern_span();
      rspan = (cfg_repl_len > MaxReplace) ? MaxReplace : cfg_repl_len;
      if (!overflowing) begin
         hit = (held_count == span);
         for (int i = 0; hit && i < span; i++) begin
            if (fold_case(held_word[i]) != fold_case(cfg_pattern[8*i +: 8]))
               hit = 1'b0;
         end
         if (hit) begin
            for (int i = 0; i < rspan; i++) beat_bytes.push_back(cfg_repl[8*i +: 8]);
         end else begin
            for (int i = 0; i < held_count; i++) beat_bytes.push_back(held_word[i]);
         end
      end
      held_count = 0;
      overflowing = 1'b0;
   endtask

   // Works out the bytes that one input beat releases, in order.
   task automatic predict_rewrite(input req_type beat);
      beat_bytes.delete();
      if (beat.in_char != cfg_delim) begin
         if (overflowing) begin
            beat_bytes.push_back(beat.in_char);
         end else if (held_count < pattern_span()) begin
            held_word[held_count] = beat.in_char;
            held_count++;
         end else begin
            for (int i = 0; i < held_count; i++) beat_bytes.push_back(held_word[i]);
            beat_bytes.push_back(beat.in_char);
            held_count = 0;
            overflowing = 1'b1;
         end
         if (beat.text_end_in) close_word();
      end else begin
         close_word();
         beat_bytes.push_back(beat.in_char);
      end
   endtask

   task automatic send_beat(input req_type beat, input logic typed, input rsp_type want);
      rsp_type r;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      predict_rewrite(beat);
      if (typed) begin
         expected_text.push_back(want);
      end else begin
         foreach (beat_bytes[i]) begin
            r.out_char = beat_bytes[i];
            r.run_last = (i == beat_bytes.size() - 1);
            r.text_end_out = r.run_last & beat.text_end_in;
            expected_text.push_back(r);
         end
      end
   endtask

   task automatic play_script(input int first, input int last);
      for (int i = first; i <= last; i++)
         send_beat(text_script[i].stim, text_script[i].typed, text_script[i].want);
   endtask

   // Waits until every expected beat has arrived and the pipeline has emptied.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_settings(input logic [63:0] pat, input logic [3:0] pat_len,
                                input logic [63:0] rep, input logic [3:0] rep_len,
                                input logic [7:0] delim);
      logic [CsrIndexWidth-1:0] regs [6];
      logic [CsrDataWidth-1:0]  vals [6];
      regs = '{RegPatternBytes, RegPatternLength, RegReplacementBytes,
               RegReplacementLength, RegDelimiter, RegUnused};
      vals = '{pat, 64'(pat_len), rep, 64'(rep_len), 64'(delim), {$urandom, $urandom}};
      for (int k = 0; k < 6; k++) begin
         csr_write_enable <= 1'b1;
         csr_index <= regs[k];
         csr_write_data <= vals[k];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cfg_pattern = pat;
      cfg_pattern_len = pat_len;
      cfg_repl = rep;
      cfg_repl_len = rep_len;
      cfg_delim = delim;
   endtask

   // Builds one whole text: mostly words close to the pattern, now and then noise.
   task automatic build_text();
      int          words;
      int          kind;
      int          len;
      int unsigned span;
      logic [7:0]  b;
      req_type     t;
      text_beats.delete();
      span = pattern_span();
      if ($urandom_range(9) == 0) begin
         len = $urandom_range(20, 1);
         for (int i = 0; i < len; i++)
            text_beats.push_back(plain_byte($urandom_range(4) == 0 ? cfg_delim
                                                                   : 8'($urandom)));
      end else begin
         if ($urandom_range(7) == 0) text_beats.push_back(plain_byte(cfg_delim));
         words = $urandom_range(5, 1);
         for (int w = 0; w < words; w++) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
               for (int i = 0; i < span; i++)
                  text_beats.push_back(plain_byte(vary_case(cfg_pattern[8*i +: 8])));
            end else if (kind < 65 && span > 1) begin
               len = $urandom_range(span - 1, 1);
               for (int i = 0; i < len; i++)
                  text_beats.push_back(plain_byte(vary_case(cfg_pattern[8*i +: 8])));
            end else if (kind < 80) begin
               for (int i = 0; i < span; i++)
                  text_beats.push_back(plain_byte(vary_case(cfg_pattern[8*i +: 8])));
               len = $urandom_range(4, 1);
               for (int i = 0; i < len; i++)
                  text_beats.push_back(plain_byte(vary_case(8'h41 + 8'($urandom_range(25)))));
            end else begin
               len = $urandom_range(10, 1);
               for (int i = 0; i < len; i++) begin
                  b = 8'($urandom);
                  if (b == cfg_delim) b = b ^ 8'h01;
                  text_beats.push_back(plain_byte(b));
               end
            end
            if (w < words - 1) begin
               text_beats.push_back(plain_byte(cfg_delim));
               if ($urandom_range(5) == 0) text_beats.push_back(plain_byte(cfg_delim));
            end
         end
         if ($urandom_range(1) == 1) text_beats.push_back(plain_byte(cfg_delim));
      end
      t = text_beats.pop_back();
      t.text_end_in = 1'b1;
      text_beats.push_back(t);
   endtask

   initial begin
      int          beats;
      logic [3:0]  pl;
      logic [3:0]  rl;
      logic [7:0]  dl;
      logic [63:0] pat;

      text_script = '{
         // Reset settings: the word made of a single zero byte is deleted.
         row(8'h20, 1'b0, 1'b1, 8'h20, 1'b0),
         row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
         row(8'h20, 1'b0, 1'b1, 8'h20, 1'b0),
         row(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1),
         row(8'h20, 1'b1, 1'b1, 8'h20, 1'b1),
         row(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
         // Three-letter pattern, eight-byte replacement, comma as separator.
         row("C", 1'b0, 1'b0, 8'h00, 1'b0), row("A", 1'b0, 1'b0, 8'h00, 1'b0),
         row("T", 1'b0, 1'b0, 8'h00, 1'b0), row(",", 1'b0, 1'b0, 8'h00, 1'b0),
         row("c", 1'b0, 1'b0, 8'h00, 1'b0), row("a", 1'b0, 1'b0, 8'h00, 1'b0),
         row("t", 1'b0, 1'b0, 8'h00, 1'b0), row("s", 1'b0, 1'b0, 8'h00, 1'b0),
         row(",", 1'b0, 1'b0, 8'h00, 1'b0), row(",", 1'b0, 1'b0, 8'h00, 1'b0),
         row("c", 1'b0, 1'b0, 8'h00, 1'b0), row("a", 1'b1, 1'b0, 8'h00, 1'b0),
         // Lengths out of range, all-ones replacement, 0xFF as separator.
         row("Z", 1'b1, 1'b0, 8'h00, 1'b0),
         row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0),
         row("z", 1'b0, 1'b0, 8'h00, 1'b0),
         row(8'hFF, 1'b1, 1'b0, 8'h00, 1'b0)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      play_script(0, 5);
      settle();
      load_settings(64'hA5A5_A5A5_A574_4163, 4'd3, 64'h746E_6168_7065_6C65, 4'd8, ",");
      play_script(6, 17);
      settle();
      load_settings(64'hFFFF_FFFF_FFFF_FF7A, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 8'hFF);
      play_script(18, 21);

      for (int phase = 0; phase < 7; phase++) begin
         settle();
         case (phase)
            0: begin pl = 4'd1;  rl = 4'd0;  dl = 8'h20; end
            1: begin pl = 4'd8;  rl = 4'd8;  dl = 8'h00; end
            2: begin pl = 4'd15; rl = 4'd15; dl = 8'hFF; end
            3: begin pl = 4'd0;  rl = 4'($urandom_range(15, 9)); dl = ","; end
            default: begin
               pl = 4'($urandom_range(8, 1));
               rl = 4'($urandom_range(8, 0));
               dl = 8'($urandom);
               if ((dl | 8'h20) >= 8'h61 && (dl | 8'h20) <= 8'h7A) dl = ".";
            end
         endcase
         // Mostly letters, so that whole words can match; a separator byte is kept out.
         for (int i = 0; i < 8; i++) begin
            pat[8*i +: 8] = ($urandom_range(4) == 0) ? 8'($urandom)
                                                     : vary_case(8'h41 + 8'($urandom_range(25)));
            if (pat[8*i +: 8] == dl) pat[8*i +: 8] = pat[8*i +: 8] ^ 8'h01;
         end
         load_settings(pat, pl, {$urandom, $urandom}, rl, dl);
         // The closing phase runs at full rate on both sides.
         idle_pct = (phase == 6) ? 0 : 15;
         stall_pct = (phase == 6) ? 0 : 15;
         beats = 0;
         while (beats < 50) begin
            build_text();
            foreach (text_beats[i]) send_beat(text_beats[i], 1'b0, '0);
            beats += text_beats.size();
         end
      end

      settle();
      if (errors == 0 && expected_text.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(13, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            $error("unexpected beat: out_char %h run_last %b text_end_out %b",
                   rsp_payload.out_char, rsp_payload.run_last, rsp_payload.text_end_out);
            errors++;
         end else begin
            seen_want = expected_text.pop_front();
            if (rsp_payload.out_char !== seen_want.out_char) begin
               $error("out_char: expected %h, got %h", seen_want.out_char, rsp_payload.out_char);
               errors++;
            end
            if (rsp_payload.run_last !== seen_want.run_last) begin
               $error("run_last: expected %b, got %b", seen_want.run_last, rsp_payload.run_last);
               errors++;
            end
            if (rsp_payload.text_end_out !== seen_want.text_end_out) begin
               $error("text_end_out: expected %b, got %b",
                      seen_want.text_end_out, rsp_payload.text_end_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> whole_word_replace_stream.f
src/wwr_pkg.sv
src/wwr_front.sv
src/wwr_queue.sv
src/wwr_back.sv
src/whole_word_replace_stream.sv
test/tb.sv
